// File: rtl/msd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types and constants of the multi-channel settle detector.
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int CHANNELS    = 6;
    localparam int FORCE_FIELDS = 6;
    localparam int FORCE_W     = 24;
    localparam int TOL_W       = 23;
    localparam int LOOPS_W     = 16;
    localparam int COUNT_W     = 17;
    localparam int MASK_W      = 6;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SETTLE_TOL   = 2'd0;
    localparam logic [1:0] REG_SETTLE_LOOPS = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_LOOPS = 2'd2;

    localparam logic [TOL_W-1:0]   RST_SETTLE_TOL    = TOL_W'(25600);
    localparam logic [LOOPS_W-1:0] RST_SETTLE_LOOPS  = LOOPS_W'(10);
    localparam logic [LOOPS_W-1:0] RST_TIMEOUT_LOOPS = LOOPS_W'(100);

    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    typedef logic signed [FORCE_W-1:0] force_t;
    typedef logic [COUNT_W-1:0]        count_t;

    typedef struct packed {
        logic [TOL_W-1:0]   settle_tolerance;
        logic [LOOPS_W-1:0] settle_loops;
        logic [LOOPS_W-1:0] timeout_loops;
    } cfg_t;

    typedef struct packed {
        logic              all_settled;
        logic              raise_complete;
        logic [MASK_W-1:0] timed_out_mask;
    } result_t;

endpackage
`default_nettype wire

// File: rtl/msd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_in_if / msd_out_if
// Valid/ready channels for sample requests and settle results.
// ----------------------------------------------------------------------------
interface msd_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic               position_done;
    logic               support_filled;
    logic signed [23:0] force_0;
    logic signed [23:0] force_1;
    logic signed [23:0] force_2;
    logic signed [23:0] force_3;
    logic signed [23:0] force_4;
    logic signed [23:0] force_5;

    modport source (
        output valid, req_type, position_done, support_filled,
        output force_0, force_1, force_2, force_3, force_4, force_5,
        input  ready
    );
    modport sink (
        input  valid, req_type, position_done, support_filled,
        input  force_0, force_1, force_2, force_3, force_4, force_5,
        output ready
    );
endinterface

interface msd_out_if;
    logic       valid;
    logic       ready;
    logic       all_settled;
    logic       raise_complete;
    logic [5:0] timed_out_mask;

    modport source (
        output valid, all_settled, raise_complete, timed_out_mask,
        input  ready
    );
    modport sink (
        input  valid, all_settled, raise_complete, timed_out_mask,
        output ready
    );
endinterface
`default_nettype wire

// File: rtl/multi_channel_settle_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_settle_detector
// Force settle detection over six channels with an APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one sample (or restart) transaction: done flags plus one
//   force per channel. out_ch returns exactly one result per transaction:
//   all_settled, raise_complete and the per-channel timeout mask.
//   One lane per channel checks its channel in parallel; the merge chain
//   lets a lane commit only when every lower channel reported settled.
//   An accepted result is registered in the result register, or in the skid
//   entry while out_ch stalls. A new transaction is taken every cycle while
//   in_ch.ready is high; each lane's state is registered before the next one.
//   A two-entry output buffer (result register plus skid register) keeps
//   in_ch.ready high while one result waits; in_ch.ready is low while both
//   entries are full, which needs out_ch stalled with a result already held,
//   and comes back the cycle after the skid entry moves up.
//   Reset clears all channel state (disarmed) and loads the register
//   defaults: tolerance 25600, settle loops 10, timeout loops 100.
//   Registers are written through APB at byte addresses 0, 4 and 8 and
//   must only change while the block is idle.
// ----------------------------------------------------------------------------
module multi_channel_settle_detector
    import msd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    msd_in_if.sink                 in_ch,
    msd_out_if.source              out_ch,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t    cfg;
    force_t  forces [FORCE_FIELDS];
    logic    in_acc;
    logic    restart;
    logic    sample;

    logic [CHANNELS-1:0] settled;
    logic [CHANNELS-1:0] check_en;
    logic [CHANNELS-1:0] timed_out;
    logic [CHANNELS-1:0] armed;
    logic [MASK_W-1:0]   mask;
    logic                all_set;
    result_t             res;

    result_t main_reg,  main_next;
    result_t skid_reg,  skid_next;
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    msd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign forces[0] = in_ch.force_0;
    assign forces[1] = in_ch.force_1;
    assign forces[2] = in_ch.force_2;
    assign forces[3] = in_ch.force_3;
    assign forces[4] = in_ch.force_4;
    assign forces[5] = in_ch.force_5;

    assign in_ch.ready = !skid_valid_reg;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign restart     = in_acc && (in_ch.req_type == REQ_RESTART);
    assign sample      = in_acc && (in_ch.req_type == REQ_SAMPLE) && in_ch.position_done;

    // merge chain: a lane is checked only past a run of settled lanes
    assign check_en[0] = sample;
    genvar g;
    generate
        for (g = 1; g < CHANNELS; g++)
        begin : g_chain
            assign check_en[g] = check_en[g-1] && settled[g-1];
        end

        for (g = 0; g < CHANNELS; g++)
        begin : g_lane
            force_t lane_force;
            if (g < FORCE_FIELDS)
            begin : g_fin
                assign lane_force = forces[g];
            end
            else
            begin : g_fzero
                assign lane_force = '0;
            end

            msd_lane u_lane (
                .clk            (clk),
                .rst_n          (rst_n),
                .cfg            (cfg),
                .restart        (restart),
                .check_en       (check_en[g]),
                .force_val      (lane_force),
                .settled        (settled[g]),
                .timed_out_next (timed_out[g]),
                .armed          (armed[g])
            );
        end

        for (g = 0; g < MASK_W; g++)
        begin : g_mask
            if (g < CHANNELS)
            begin : g_on
                assign mask[g] = timed_out[g];
            end
            else
            begin : g_off
                assign mask[g] = 1'b0;
            end
        end
    endgenerate

    assign all_set = sample && (&settled);

    always_comb
    begin
        res.all_settled    = all_set;
        res.raise_complete = all_set && in_ch.support_filled;
        res.timed_out_mask = mask;
    end

    // result register with skid entry
    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (main_valid_reg && !out_ch.ready)
        begin
            if (in_acc)
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            main_next       = skid_reg;
            main_valid_next = 1'b1;
            skid_valid_next = 1'b0;
        end
        else
        begin
            main_next       = res;
            main_valid_next = in_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_ch.valid          = main_valid_reg;
    assign out_ch.all_settled    = main_reg.all_settled;
    assign out_ch.raise_complete = main_reg.raise_complete;
    assign out_ch.timed_out_mask = main_reg.timed_out_mask;

    // the skid entry is only ever filled behind a held result
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid without result entry");

    // a restart leaves every channel disarmed
    a_restart_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (armed == '0))
        else $error("channel still armed after restart");

    // all settled only when the chain reached and passed every lane
    a_all_needs_chain: assert property (@(posedge clk) disable iff (!rst_n)
        all_set |-> (check_en[CHANNELS-1] && (&settled)))
        else $error("all_settled without full channel chain");

    // a lane is never checked on a restart or outside a sample transaction
    a_check_only_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (check_en != '0) |-> (sample && !restart))
        else $error("lane checked outside a sample transaction");

endmodule
`default_nettype wire

// File: rtl/msd_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_cfg_regs
// APB register file holding tolerance and loop limits.
// ----------------------------------------------------------------------------
module msd_cfg_regs
    import msd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_SETTLE_TOL:    cfg_next.settle_tolerance = pwdata[TOL_W-1:0];
                REG_SETTLE_LOOPS:  cfg_next.settle_loops     = pwdata[LOOPS_W-1:0];
                REG_TIMEOUT_LOOPS: cfg_next.timeout_loops    = pwdata[LOOPS_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SETTLE_TOL:    prdata = DATA_W'(cfg_reg.settle_tolerance);
            REG_SETTLE_LOOPS:  prdata = DATA_W'(cfg_reg.settle_loops);
            REG_TIMEOUT_LOOPS: prdata = DATA_W'(cfg_reg.timeout_loops);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_tolerance <= RST_SETTLE_TOL;
            cfg_reg.settle_loops     <= RST_SETTLE_LOOPS;
            cfg_reg.timeout_loops    <= RST_TIMEOUT_LOOPS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/msd_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_lane
// Settle check for one force channel: arm, timeout, deviation and count.
// ----------------------------------------------------------------------------
module msd_lane
    import msd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   restart,
    input  wire logic   check_en,
    input  wire force_t force_val,
    output logic        settled,
    output logic        timed_out_next,
    output logic        armed
);

    logic   armed_reg,   armed_next;
    force_t mid_reg,     mid_next;
    count_t scnt_reg,    scnt_next;
    count_t tcnt_reg,    tcnt_next;

    logic   armed_upd;
    force_t mid_upd;
    count_t scnt_upd;
    count_t tcnt_upd;

    logic signed [FORCE_W:0] diff;
    logic        [FORCE_W:0] dev;
    logic signed [FORCE_W:0] sum;
    logic                    tmo_hit;
    logic                    dev_big;

    assign diff    = FORCE_W'(0) + ({force_val[FORCE_W-1], force_val}
                     - {mid_reg[FORCE_W-1], mid_reg});
    assign dev     = diff[FORCE_W] ? (FORCE_W+1)'(-diff) : diff;
    assign sum     = {force_val[FORCE_W-1], force_val} + {mid_reg[FORCE_W-1], mid_reg};
    assign tmo_hit = tcnt_reg > COUNT_W'(cfg.timeout_loops);
    assign dev_big = dev > (FORCE_W+1)'(cfg.settle_tolerance);

    // one check of this channel
    always_comb
    begin
        armed_upd = armed_reg;
        mid_upd   = mid_reg;
        scnt_upd  = scnt_reg;
        tcnt_upd  = tcnt_reg;
        settled   = 1'b0;
        if (!armed_reg)
        begin
            armed_upd = 1'b1;
            mid_upd   = force_val;
            scnt_upd  = '0;
            tcnt_upd  = '0;
        end
        else if (tmo_hit)
        begin
            settled = 1'b1;
        end
        else
        begin
            if (tcnt_reg != COUNT_MAX)
                tcnt_upd = tcnt_reg + 1'b1;
            if (dev_big)
            begin
                scnt_upd = '0;
                mid_upd  = sum[FORCE_W:1];   // floor of the halved sum
            end
            else if (scnt_reg > COUNT_W'(cfg.settle_loops))
            begin
                settled = 1'b1;
            end
            else if (scnt_reg != COUNT_MAX)
            begin
                scnt_upd = scnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        armed_next = armed_reg;
        mid_next   = mid_reg;
        scnt_next  = scnt_reg;
        tcnt_next  = tcnt_reg;
        if (restart)
        begin
            armed_next = 1'b0;
            mid_next   = '0;
            scnt_next  = '0;
            tcnt_next  = '0;
        end
        else if (check_en)
        begin
            armed_next = armed_upd;
            mid_next   = mid_upd;
            scnt_next  = scnt_upd;
            tcnt_next  = tcnt_upd;
        end
    end

    assign timed_out_next = armed_next && (tcnt_next > COUNT_W'(cfg.timeout_loops));
    assign armed          = armed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            mid_reg   <= '0;
            scnt_reg  <= '0;
            tcnt_reg  <= '0;
        end
        else
        begin
            armed_reg <= armed_next;
            mid_reg   <= mid_next;
            scnt_reg  <= scnt_next;
            tcnt_reg  <= tcnt_next;
        end
    end

endmodule
`default_nettype wire
